FILE: src/flood_relay_duplicate_filter_top_assert.svh
// ============================================================================
// Flood relay duplicate filter assertion macros
// Concurrent assertion wrappers shared by the filter RTL. Synthesis builds
// see empty bodies.
// ============================================================================
`ifndef FLOOD_RELAY_DUPLICATE_FILTER_TOP_ASSERT_SVH
`define FLOOD_RELAY_DUPLICATE_FILTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define FRDF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("frdf assertion failed");

// Condition must never be true at a clock edge outside reset.
`define FRDF_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("frdf forbidden condition seen");

`else

`define FRDF_ASSERT(label, clk, rst_n, prop)

`define FRDF_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: src/frdf_pkg.sv
// ============================================================================
// Flood relay duplicate filter package
// Field widths, slot record type, verdict codes and the wrap-safe time
// comparison shared by the interfaces and the filter.
// ============================================================================
package frdf_pkg;

    localparam int HASH_W = 32;
    localparam int HOP_W  = 8;
    localparam int TIME_W = 32;
    localparam int LIFE_W = 31;
    localparam int LIVE_W = 6;
    localparam int CNT_W  = 32;

    localparam logic [HASH_W-1:0] EMPTY_HASH     = '0;
    localparam logic [HASH_W-1:0] FOLDED_HASH    = HASH_W'(1);
    localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(30000);

    typedef enum logic [1:0] {
        VERDICT_FORWARD = 2'd0,
        VERDICT_DUP     = 2'd1,
        VERDICT_DEAD    = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [TIME_W-1:0] expiry;
    } slot_t;

    // True when a - b, taken as a signed difference, is negative.
    function automatic logic time_before(input logic [TIME_W-1:0] a,
                                         input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

endpackage

FILE: src/frdf_if.sv
// ============================================================================
// Flood relay duplicate filter channels
// Valid/ready channels for packet beats into the filter and result beats
// out of it.
// ============================================================================
interface frdf_pkt_if;
    import frdf_pkg::*;

    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] packet_hash;
    logic [HOP_W-1:0]  hop_limit;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, packet_hash, hop_limit, now_ms, input ready);
    modport sink   (input valid, packet_hash, hop_limit, now_ms, output ready);
endinterface

interface frdf_res_if;
    import frdf_pkg::*;

    logic              valid;
    logic              ready;
    verdict_t          verdict;
    logic [HOP_W-1:0]  next_hop_limit;
    logic [LIVE_W-1:0] live_count;
    logic [CNT_W-1:0]  dup_total;
    logic [CNT_W-1:0]  dead_total;
    logic [CNT_W-1:0]  forward_total;

    modport source (output valid, verdict, next_hop_limit, live_count, dup_total,
                    dead_total, forward_total, input ready);
    modport sink   (input valid, verdict, next_hop_limit, live_count, dup_total,
                    dead_total, forward_total, output ready);
endinterface

FILE: src/flood_relay_duplicate_filter_top.sv
// ============================================================================
// Flood relay duplicate filter
// Time-limited hash cache that drops duplicate and hop-exhausted packets and
// records forwarded ones, kept in one slot memory with registered reads.
// ============================================================================
//
//  Channel   Dir  Handshake          Beat contents
//  pkt       in   valid / ready      packet_hash, hop_limit, now_ms
//  res       out  valid / ready      verdict, next_hop_limit, live_count, totals
//  cfg       in   cfg_wr_en only     entry lifetime in ms, 31 bits
//
//  A duplicate or dead packet gets its result after the lookup walk alone;
//  a forwarded packet also passes a slot write and the expiry sweep. Both
//  the walk and the sweep read the slot memory one entry per cycle through
//  its single read port.
//  After reset a clearing pass writes all SLOTS entries, one per cycle, and
//  no packet is accepted until it ends. The result register holds one beat;
//  a new packet is taken while it waits, and a finished result waits for it.
//
`include "flood_relay_duplicate_filter_top_assert.svh"

module flood_relay_duplicate_filter_top #(
    parameter int SLOTS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [frdf_pkg::LIFE_W-1:0] cfg_wr_data,
    frdf_pkt_if.sink                    pkt,
    frdf_res_if.source                  res
);
    import frdf_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOT_CNT = CW'(SLOTS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // Slot memory and its ports
    slot_t             mem [SLOTS];
    slot_t             rd_data_reg;
    logic              rd_vld_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    slot_t             wr_data;

    state_t            state_reg;
    logic [CW-1:0]     idx_reg;
    logic [LIFE_W-1:0] life_reg;

    logic [HASH_W-1:0] hash_reg;
    logic [HOP_W-1:0]  hops_reg;
    logic [TIME_W-1:0] now_reg;

    logic              dup_reg;
    logic              found_reg;
    logic [AW-1:0]     pick_reg;
    logic              have_reg;
    logic [AW-1:0]     min_idx_reg;
    logic [TIME_W-1:0] min_exp_reg;

    logic [LIVE_W-1:0] live_acc_reg;
    logic [LIVE_W-1:0] live_reg;
    logic [CNT_W-1:0]  dup_cnt_reg;
    logic [CNT_W-1:0]  dead_cnt_reg;
    logic [CNT_W-1:0]  fwd_cnt_reg;
    verdict_t          verdict_reg;

    logic              out_vld_reg;
    verdict_t          out_verdict_reg;
    logic [HOP_W-1:0]  out_hop_reg;
    logic [LIVE_W-1:0] out_live_reg;
    logic [CNT_W-1:0]  out_dup_reg;
    logic [CNT_W-1:0]  out_dead_reg;
    logic [CNT_W-1:0]  out_fwd_reg;

    // Evaluation of the entry on the memory read port
    logic              e_expired;
    logic              e_empty;
    logic              e_match;
    logic              e_last;
    logic              dup_next;
    logic [LIVE_W-1:0] live_acc_next;
    logic              out_load;

    assign pkt.ready = (state_reg == ST_IDLE);

    assign res.valid          = out_vld_reg;
    assign res.verdict        = out_verdict_reg;
    assign res.next_hop_limit = out_hop_reg;
    assign res.live_count     = out_live_reg;
    assign res.dup_total      = out_dup_reg;
    assign res.dead_total     = out_dead_reg;
    assign res.forward_total  = out_fwd_reg;

    always_comb
    begin
        e_expired     = !time_before(now_reg, rd_data_reg.expiry);
        e_empty       = (rd_data_reg.hash == EMPTY_HASH);
        e_match       = (rd_data_reg.hash == hash_reg);
        e_last        = (rd_idx_reg == LAST_IDX);
        dup_next      = dup_reg | (e_match & ~e_expired);
        live_acc_next = live_acc_reg + LIVE_W'(~e_empty & ~e_expired);
        out_load      = (state_reg == ST_DONE) && (!out_vld_reg || res.ready);
    end

    always_comb
    begin
        rd_en   = ((state_reg == ST_SCAN) || (state_reg == ST_SWEEP)) && (idx_reg < SLOT_CNT);
        rd_addr = idx_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_WRITE:
            begin
                wr_en          = 1'b1;
                wr_addr        = found_reg ? pick_reg : min_idx_reg;
                wr_data.hash   = hash_reg;
                wr_data.expiry = now_reg + TIME_W'(life_reg);
            end
            ST_SWEEP:
            begin
                // Stale slot: empty the hash, keep the expiry as it was.
                wr_en          = rd_vld_reg && !e_empty && e_expired;
                wr_addr        = rd_idx_reg;
                wr_data.hash   = EMPTY_HASH;
                wr_data.expiry = rd_data_reg.expiry;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            rd_idx_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            life_reg <= LIFETIME_RESET;
        end
        else if (cfg_wr_en)
        begin
            life_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            dup_reg      <= 1'b0;
            found_reg    <= 1'b0;
            have_reg     <= 1'b0;
            live_acc_reg <= '0;
            live_reg     <= '0;
            dup_cnt_reg  <= '0;
            dead_cnt_reg <= '0;
            fwd_cnt_reg  <= '0;
            verdict_reg  <= VERDICT_FORWARD;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    idx_reg <= idx_reg + CW'(1);
                    if (idx_reg[AW-1:0] == LAST_IDX)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (pkt.valid)
                    begin
                        hash_reg  <= (pkt.packet_hash == EMPTY_HASH) ? FOLDED_HASH
                                                                      : pkt.packet_hash;
                        hops_reg  <= pkt.hop_limit;
                        now_reg   <= pkt.now_ms;
                        idx_reg   <= '0;
                        dup_reg   <= 1'b0;
                        found_reg <= 1'b0;
                        have_reg  <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg < SLOT_CNT)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    if (rd_vld_reg)
                    begin
                        dup_reg <= dup_next;
                        // First reusable slot wins; the soonest expiry is the fallback.
                        if (!found_reg && (e_match || e_empty || e_expired))
                        begin
                            found_reg <= 1'b1;
                            pick_reg  <= rd_idx_reg;
                        end
                        if (!have_reg || time_before(rd_data_reg.expiry, min_exp_reg))
                        begin
                            have_reg    <= 1'b1;
                            min_idx_reg <= rd_idx_reg;
                            min_exp_reg <= rd_data_reg.expiry;
                        end
                        if (e_last)
                        begin
                            priority if (dup_next)
                            begin
                                dup_cnt_reg <= dup_cnt_reg + CNT_W'(1);
                                verdict_reg <= VERDICT_DUP;
                                state_reg   <= ST_DONE;
                            end
                            else if (hops_reg == '0)
                            begin
                                dead_cnt_reg <= dead_cnt_reg + CNT_W'(1);
                                verdict_reg  <= VERDICT_DEAD;
                                state_reg    <= ST_DONE;
                            end
                            else
                            begin
                                fwd_cnt_reg <= fwd_cnt_reg + CNT_W'(1);
                                verdict_reg <= VERDICT_FORWARD;
                                state_reg   <= ST_WRITE;
                            end
                        end
                    end
                end
                ST_WRITE:
                begin
                    idx_reg      <= '0;
                    live_acc_reg <= '0;
                    state_reg    <= ST_SWEEP;
                end
                ST_SWEEP:
                begin
                    if (idx_reg < SLOT_CNT)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    if (rd_vld_reg)
                    begin
                        live_acc_reg <= live_acc_next;
                        if (e_last)
                        begin
                            live_reg  <= live_acc_next;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result beat payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_verdict_reg <= verdict_reg;
            out_hop_reg     <= (verdict_reg == VERDICT_FORWARD) ? hops_reg - HOP_W'(1)
                                                                 : '0;
            out_live_reg    <= live_reg;
            out_dup_reg     <= dup_cnt_reg;
            out_dead_reg    <= dead_cnt_reg;
            out_fwd_reg     <= fwd_cnt_reg;
        end
    end

    `FRDF_ASSERT(a_accept_starts_scan, clk, rst_n, (pkt.valid && pkt.ready) |=> (state_reg == ST_SCAN))
    `FRDF_NEVER(a_sweep_port_clash, clk, rst_n, wr_en && rd_en && (wr_addr == rd_addr))
    `FRDF_ASSERT(a_live_in_range, clk, rst_n, (SLOTS > 63) || (int'(live_reg) <= SLOTS))
    `FRDF_ASSERT(a_result_waits, clk, rst_n, (state_reg == ST_DONE && out_vld_reg && !res.ready) |=> (state_reg == ST_DONE))

endmodule

FILE: sim/flood_relay_duplicate_filter_top_tb.sv
// ============================================================================
// Flood relay duplicate filter testbench
// Drives packet beats into the filter and checks every result beat against a
// cycle-free model of the hash cache, or against the beat a directed row gives.
// A short directed table comes first, then random phases under several entry
// lifetimes. Random stalls hit both channels, with two long result hold-offs.
// ============================================================================
module flood_relay_duplicate_filter_top_tb;
    import frdf_pkg::*;

    localparam int SLOTS           = 32;
    localparam int POOL_SIZE       = 48;
    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 90;
    localparam int HOLD_OFF_CYCLES = 700;
    localparam int DRAIN_CYCLES    = 2 * SLOTS + 10;
    localparam int WATCHDOG_LIMIT  = 5000;

    typedef struct packed {
        verdict_t          verdict;
        logic [HOP_W-1:0]  next_hop_limit;
        logic [LIVE_W-1:0] live_count;
        logic [CNT_W-1:0]  dup_total;
        logic [CNT_W-1:0]  dead_total;
        logic [CNT_W-1:0]  forward_total;
    } verdict_beat_t;

    typedef struct packed {
        logic [HASH_W-1:0] packet_hash;
        logic [HOP_W-1:0]  hop_limit;
        logic [TIME_W-1:0] now_ms;
        logic              known;
        verdict_beat_t     beat;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [LIFE_W-1:0] cfg_wr_data;

    frdf_pkt_if pkt_ch ();
    frdf_res_if res_ch ();

    flood_relay_duplicate_filter_top #(
        .SLOTS(SLOTS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pkt        (pkt_ch),
        .res        (res_ch)
    );

    // Model of the hash cache and its counters.
    logic [HASH_W-1:0] cache_hash   [SLOTS];
    logic [TIME_W-1:0] cache_expiry [SLOTS];
    logic [LIVE_W-1:0] cache_live;
    logic [CNT_W-1:0]  dup_cnt;
    logic [CNT_W-1:0]  dead_cnt;
    logic [CNT_W-1:0]  fwd_cnt;
    logic [LIFE_W-1:0] lifetime_ms;

    verdict_beat_t     pending_q [$];
    stim_row_t         directed_rows [$];
    verdict_beat_t     want;
    logic [HASH_W-1:0] hash_pool [POOL_SIZE];
    int                errors;
    int                results_seen;
    int                stall_cycles;

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // True when a - b is negative as a signed difference.
    function automatic logic is_earlier(input logic [TIME_W-1:0] a,
                                        input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

    function automatic verdict_beat_t filter_packet(input logic [HASH_W-1:0] raw_hash,
                                                    input logic [HOP_W-1:0]  hops,
                                                    input logic [TIME_W-1:0] now);
        logic [HASH_W-1:0] h;
        logic              seen;
        logic              chosen;
        logic              have_oldest;
        logic [TIME_W-1:0] oldest_expiry;
        int                slot;
        int                live;
        int                i;
        verdict_beat_t     beat;
        h = (raw_hash == EMPTY_HASH) ? FOLDED_HASH : raw_hash;
        seen = 1'b0;
        for (i = 0; i < SLOTS; i++)
        begin
            if (cache_hash[i] == h && is_earlier(now, cache_expiry[i]))
                seen = 1'b1;
        end
        beat = '0;
        if (seen)
        begin
            dup_cnt = dup_cnt + 1'b1;
            beat.verdict = VERDICT_DUP;
        end
        else if (hops == '0)
        begin
            dead_cnt = dead_cnt + 1'b1;
            beat.verdict = VERDICT_DEAD;
        end
        else
        begin
            // First reusable slot wins; otherwise evict the soonest to expire.
            chosen = 1'b0;
            have_oldest = 1'b0;
            oldest_expiry = '0;
            slot = 0;
            for (i = 0; i < SLOTS; i++)
            begin
                if (!chosen)
                begin
                    if (cache_hash[i] == h || cache_hash[i] == EMPTY_HASH ||
                        !is_earlier(now, cache_expiry[i]))
                    begin
                        slot = i;
                        chosen = 1'b1;
                    end
                    else if (!have_oldest || is_earlier(cache_expiry[i], oldest_expiry))
                    begin
                        have_oldest = 1'b1;
                        slot = i;
                        oldest_expiry = cache_expiry[i];
                    end
                end
            end
            cache_hash[slot] = h;
            cache_expiry[slot] = now + TIME_W'(lifetime_ms);
            live = 0;
            for (i = 0; i < SLOTS; i++)
            begin
                if (cache_hash[i] != EMPTY_HASH)
                begin
                    if (!is_earlier(now, cache_expiry[i]))
                        cache_hash[i] = EMPTY_HASH;
                    else
                        live++;
                end
            end
            cache_live = LIVE_W'(live);
            fwd_cnt = fwd_cnt + 1'b1;
            beat.verdict = VERDICT_FORWARD;
            beat.next_hop_limit = hops - 1'b1;
        end
        beat.live_count = cache_live;
        beat.dup_total = dup_cnt;
        beat.dead_total = dead_cnt;
        beat.forward_total = fwd_cnt;
        return beat;
    endfunction

    // Mostly short gaps, with runs of none and an occasional long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 60);
    endfunction

    task automatic stim_row(input logic [HASH_W-1:0] hash, input logic [HOP_W-1:0] hops,
                            input logic [TIME_W-1:0] now);
        stim_row_t row;
        row = '0;
        row.packet_hash = hash;
        row.hop_limit = hops;
        row.now_ms = now;
        directed_rows.push_back(row);
    endtask

    task automatic stim_row_known(input logic [HASH_W-1:0] hash, input logic [HOP_W-1:0] hops,
                                  input logic [TIME_W-1:0] now, input verdict_t verdict,
                                  input logic [HOP_W-1:0] next_hops,
                                  input logic [LIVE_W-1:0] live,
                                  input logic [CNT_W-1:0] dups, input logic [CNT_W-1:0] deads,
                                  input logic [CNT_W-1:0] fwds);
        stim_row_t row;
        row.packet_hash = hash;
        row.hop_limit = hops;
        row.now_ms = now;
        row.known = 1'b1;
        row.beat.verdict = verdict;
        row.beat.next_hop_limit = next_hops;
        row.beat.live_count = live;
        row.beat.dup_total = dups;
        row.beat.dead_total = deads;
        row.beat.forward_total = fwds;
        directed_rows.push_back(row);
    endtask

    // Offers one packet beat and records its expected result once accepted.
    task automatic offer_packet(input stim_row_t row);
        verdict_beat_t predicted;
        pkt_ch.valid <= 1'b1;
        pkt_ch.packet_hash <= row.packet_hash;
        pkt_ch.hop_limit <= row.hop_limit;
        pkt_ch.now_ms <= row.now_ms;
        @(posedge clk);
        while (!pkt_ch.ready)
            @(posedge clk);
        predicted = filter_packet(row.packet_hash, row.hop_limit, row.now_ms);
        pending_q.push_back(row.known ? row.beat : predicted);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            pkt_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // The lifetime is only changed once every pending result has drained.
    task automatic write_lifetime(input logic [LIFE_W-1:0] value);
        idle_sender(1);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lifetime_ms = value;
    endtask

    always @(posedge clk)
    begin
        if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result beat with no packet waiting for it");
                errors++;
            end
            else
            begin
                want = pending_q.pop_front();
                results_seen <= results_seen + 1;
                if (res_ch.verdict !== want.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", want.verdict, res_ch.verdict);
                    errors++;
                end
                if (res_ch.next_hop_limit !== want.next_hop_limit)
                begin
                    $error("next_hop_limit: expected %0d, got %0d",
                           want.next_hop_limit, res_ch.next_hop_limit);
                    errors++;
                end
                if (res_ch.live_count !== want.live_count)
                begin
                    $error("live_count: expected %0d, got %0d",
                           want.live_count, res_ch.live_count);
                    errors++;
                end
                if (res_ch.dup_total !== want.dup_total)
                begin
                    $error("dup_total: expected %0d, got %0d", want.dup_total, res_ch.dup_total);
                    errors++;
                end
                if (res_ch.dead_total !== want.dead_total)
                begin
                    $error("dead_total: expected %0d, got %0d",
                           want.dead_total, res_ch.dead_total);
                    errors++;
                end
                if (res_ch.forward_total !== want.forward_total)
                begin
                    $error("forward_total: expected %0d, got %0d",
                           want.forward_total, res_ch.forward_total);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        @(posedge clk);
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : result_sink
        int   gap;
        logic held_early;
        logic held_late;
        held_early = 1'b0;
        held_late = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            // Long hold-offs let the filter fill up and push back on packets.
            if ((!held_early && results_seen >= 40) || (!held_late && results_seen >= 300))
            begin
                if (held_early)
                    held_late = 1'b1;
                held_early = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin : packet_source
        logic [LIFE_W-1:0] phase_life [PHASES];
        logic [TIME_W-1:0] life_span;
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] step;
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] last_hash;
        logic [HOP_W-1:0]  hops;
        stim_row_t         row;
        int                p;
        int                n;
        int                k;
        int                roll;

        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        pkt_ch.valid <= 1'b0;
        pkt_ch.packet_hash <= '0;
        pkt_ch.hop_limit <= '0;
        pkt_ch.now_ms <= '0;
        for (k = 0; k < SLOTS; k++)
        begin
            cache_hash[k] = EMPTY_HASH;
            cache_expiry[k] = '0;
        end
        cache_live = '0;
        dup_cnt = '0;
        dead_cnt = '0;
        fwd_cnt = '0;
        lifetime_ms = LIFETIME_RESET;

        // Directed rows run under the reset lifetime of 30000 ms.
        stim_row_known(32'h0000_0000, 8'd5,   32'd100,   VERDICT_FORWARD, 8'd4,   6'd1, 0, 0, 1);
        stim_row_known(32'h0000_0001, 8'd3,   32'd101,   VERDICT_DUP,     8'd0,   6'd1, 1, 0, 1);
        stim_row_known(32'hFFFF_FFFF, 8'd0,   32'd102,   VERDICT_DEAD,    8'd0,   6'd1, 1, 1, 1);
        stim_row_known(32'hFFFF_FFFF, 8'd255, 32'd103,   VERDICT_FORWARD, 8'd254, 6'd2, 1, 1, 2);
        stim_row_known(32'hFFFF_FFFF, 8'd1,   32'd104,   VERDICT_DUP,     8'd0,   6'd2, 2, 1, 2);
        // At exactly its expiry time an entry no longer counts as live.
        stim_row_known(32'h0000_0000, 8'd0,   32'd30100, VERDICT_DEAD,    8'd0,   6'd2, 2, 2, 2);
        stim_row_known(32'h0000_0001, 8'd1,   32'd30100, VERDICT_FORWARD, 8'd0,   6'd2, 2, 2, 3);
        stim_row(32'h1234_5678, 8'd7,   32'h0000_9000);
        // A duplicate wins over a zero hop limit.
        stim_row(32'h1234_5678, 8'd0,   32'h0000_9001);
        stim_row(32'h8000_0000, 8'd128, 32'hFFFF_FFF0);
        stim_row(32'h7FFF_FFFF, 8'd64,  32'h0000_0010);
        stim_row(32'h8000_0000, 8'd2,   32'h0000_0011);
        stim_row(32'h5555_5555, 8'hAA,  32'h5555_AAAA);
        stim_row(32'hAAAA_AAAA, 8'h55,  32'hAAAA_5555);
        stim_row(32'h1234_5678, 8'd1,   32'hAAAA_5556);
        stim_row(32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF);

        phase_life[0] = 31'h7FFF_FFFF;
        phase_life[1] = 31'd1;
        phase_life[2] = 31'd0;
        phase_life[3] = 31'd40;
        phase_life[4] = 31'd30000;
        phase_life[5] = LIFE_W'($urandom_range(5000, 2));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer_packet(directed_rows[i]);
            idle_sender(pick_gap());
        end

        last_hash = FOLDED_HASH;
        for (p = 0; p < PHASES; p++)
        begin
            write_lifetime(phase_life[p]);
            life_span = TIME_W'(phase_life[p]);
            for (k = 0; k < POOL_SIZE; k++)
                hash_pool[k] = $urandom();
            clock_ms = $urandom();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Time mostly creeps forward, with jumps across the lifetime
                // and now and then anywhere in the wrapping range.
                roll = $urandom_range(0, 9);
                if (roll < 5)
                    step = $urandom_range(0, 3);
                else if (roll < 8)
                    step = $urandom_range(0, life_span / 8 + 1);
                else if (roll < 9)
                    step = $urandom_range(0, life_span + 2);
                else
                    step = $urandom();
                clock_ms = clock_ms + step;

                roll = $urandom_range(0, 99);
                if (roll < 70)
                    hash = hash_pool[$urandom_range(0, POOL_SIZE - 1)];
                else if (roll < 80)
                    hash = last_hash;
                else if (roll < 88)
                    hash = EMPTY_HASH;
                else if (roll < 90)
                    hash = FOLDED_HASH;
                else
                    hash = $urandom();

                roll = $urandom_range(0, 99);
                if (roll < 12)
                    hops = '0;
                else if (roll < 17)
                    hops = 8'hFF;
                else if (roll < 22)
                    hops = 8'd1;
                else
                    hops = HOP_W'($urandom_range(1, 255));

                row = '0;
                row.packet_hash = hash;
                row.hop_limit = hops;
                row.now_ms = clock_ms;
                offer_packet(row);
                last_hash = hash;
                idle_sender(pick_gap());
            end
        end

        idle_sender(1);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/frdf_pkg.sv
src/frdf_if.sv
src/flood_relay_duplicate_filter_top.sv
sim/flood_relay_duplicate_filter_top_tb.sv
